### src/v3a_pkg.sv
// Shared definitions for the 3D vector arithmetic unit.
// Operation codes carried on the request side-band; no dependencies.
`default_nettype none
package v3a_pkg;

   typedef logic [3:0] op_type;

   localparam op_type OP_NEG    = 4'd0;
   localparam op_type OP_SCALE  = 4'd1;
   localparam op_type OP_DIV    = 4'd2;
   localparam op_type OP_ADD    = 4'd3;
   localparam op_type OP_SUB    = 4'd4;
   localparam op_type OP_LEN    = 4'd5;
   localparam op_type OP_NORM   = 4'd6;
   localparam op_type OP_DOT    = 4'd7;
   localparam op_type OP_CROSS  = 4'd8;
   localparam op_type OP_PROJ   = 4'd9;
   localparam op_type OP_REJ    = 4'd10;

endpackage
`default_nettype wire

### src/v3a_sqrt_cell.sv
// One cell of the integer square root chain: retires one root bit per cycle while en is high.
// Uses no package items.
`default_nettype none
module v3a_sqrt_cell #(
   parameter int W = 32
) (
   input  logic             clock,
   input  logic             en,
   input  logic [2*W-1:0]   rad_in,
   input  logic [W+1:0]     rem_in,
   input  logic [W-1:0]     root_in,
   output logic [2*W-1:0]   rad_out,
   output logic [W+1:0]     rem_out,
   output logic [W-1:0]     root_out
);

   logic [W+3:0]   remw;
   logic [W+3:0]   trial;
   logic [W+3:0]   diff;
   logic           ge;
   logic [2*W-1:0] rad_ff;
   logic [W+1:0]   rem_ff;
   logic [W-1:0]   root_ff;

   always_comb begin
      remw  = {rem_in, rad_in[2*W-1 -: 2]};
      trial = (W+4)'({root_in, 2'b01});
      ge    = (remw >= trial);
      diff  = remw - trial;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= {rad_in[2*W-3:0], 2'b00};
         rem_ff  <= ge ? diff[W+1:0] : remw[W+1:0];
         root_ff <= {root_in[W-2:0], ge};
      end
   end

   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule
`default_nettype wire

### src/v3a_div_cell.sv
// One cell of the restoring divider chain: one quotient bit per cycle, while en is high, for
// three lanes sharing a divisor. Uses no package items.
`default_nettype none
module v3a_div_cell #(
   parameter int W = 32
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [2*W-1:0]          d_in,
   input  logic [2:0][2*W-1:0]     rem_in,
   input  logic [2:0][W-1:0]       num_in,
   input  logic [2:0][W-1:0]       q_in,
   output logic [2*W-1:0]          d_out,
   output logic [2:0][2*W-1:0]     rem_out,
   output logic [2:0][W-1:0]       num_out,
   output logic [2:0][W-1:0]       q_out
);

   localparam int PW = 2 * W;

   logic [PW:0]             rw [3];
   logic [PW:0]             df [3];
   logic [2:0]              ge;
   logic [PW-1:0]           d_ff;
   logic [2:0][PW-1:0]      rem_ff;
   logic [2:0][W-1:0]       num_ff;
   logic [2:0][W-1:0]       q_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rw[i] = {rem_in[i], num_in[i][W-1]};
         df[i] = rw[i] - {1'b0, d_in};
         ge[i] = (rw[i] >= {1'b0, d_in});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
         for (int i = 0; i < 3; i++) begin
            rem_ff[i] <= ge[i] ? df[i][PW-1:0] : rw[i][PW-1:0];
            num_ff[i] <= {num_in[i][W-2:0], 1'b0};
            q_ff[i]   <= {q_in[i][W-2:0], ge[i]};
         end
      end
   end

   assign d_out   = d_ff;
   assign rem_out = rem_ff;
   assign num_out = num_ff;
   assign q_out   = q_ff;

endmodule
`default_nettype wire

### src/v3a_front.sv
// Front end of the vector unit: products, sums and the results that need no
// root or quotient. Three pipeline stages. Depends on v3a_pkg.
`default_nettype none
module v3a_front #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  v3a_pkg::op_type     op,
   input  logic [2:0][W-1:0]   a,
   input  logic [2:0][W-1:0]   b,
   input  logic [W-1:0]        s,
   output logic                out_valid,
   output v3a_pkg::op_type     out_op,
   output logic [2:0][W-1:0]   out_vec,
   output logic [2:0][W-1:0]   out_bv,
   output logic [W-1:0]        out_sc,
   output logic [W-1:0]        out_s,
   output logic [2*W-1:0]      out_rad,
   output logic [2*W-1:0]      out_abmag,
   output logic                out_abneg,
   output logic [2*W-1:0]      out_bb
);
   import v3a_pkg::*;

   localparam int PW = 2 * W;
   localparam int XW = 2 * W + 2;
   localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

   function automatic logic [W-1:0] sat(input logic [XW-1:0] v);
      logic [XW-W:0] hi;
      hi = v[XW-1:W-1];
      if (&hi || ~|hi) sat = v[W-1:0];
      else if (v[XW-1]) sat = SMIN;
      else sat = SMAX;
   endfunction

   // stage 1: products
   logic [W-1:0]              m0 [3];
   logic                      s1_vld_ff;
   op_type                    s1_op_ff;
   logic [2:0][W-1:0]         s1_a_ff, s1_b_ff;
   logic [W-1:0]              s1_s_ff;
   logic signed [PW-1:0]      s1_p0_ff [3];
   logic signed [PW-1:0]      s1_p1_ff [3];
   logic signed [PW-1:0]      s1_c_ff [6];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (op)
            OP_SCALE:        m0[i] = s;
            OP_LEN, OP_NORM: m0[i] = a[i];
            default:         m0[i] = b[i];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (en) s1_vld_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff <= op;
         s1_a_ff  <= a;
         s1_b_ff  <= b;
         s1_s_ff  <= s;
         for (int i = 0; i < 3; i++) begin
            s1_p0_ff[i] <= PW'($signed(a[i])) * PW'($signed(m0[i]));
            s1_p1_ff[i] <= PW'($signed(b[i])) * PW'($signed(b[i]));
         end
         s1_c_ff[0] <= PW'($signed(a[1])) * PW'($signed(b[2]));
         s1_c_ff[1] <= PW'($signed(a[2])) * PW'($signed(b[1]));
         s1_c_ff[2] <= PW'($signed(a[2])) * PW'($signed(b[0]));
         s1_c_ff[3] <= PW'($signed(a[0])) * PW'($signed(b[2]));
         s1_c_ff[4] <= PW'($signed(a[0])) * PW'($signed(b[1]));
         s1_c_ff[5] <= PW'($signed(a[1])) * PW'($signed(b[0]));
      end
   end

   // stage 2: sums and cross differences
   logic                      s2_vld_ff;
   op_type                    s2_op_ff;
   logic [2:0][W-1:0]         s2_a_ff, s2_b_ff;
   logic [W-1:0]              s2_s_ff;
   logic signed [PW-1:0]      s2_p0_ff [3];
   logic signed [XW-1:0]      s2_sum0_ff, s2_sum1_ff;
   logic signed [PW:0]        s2_cd_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (en) s2_vld_ff <= s1_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_op_ff   <= s1_op_ff;
         s2_a_ff    <= s1_a_ff;
         s2_b_ff    <= s1_b_ff;
         s2_s_ff    <= s1_s_ff;
         s2_p0_ff   <= s1_p0_ff;
         s2_sum0_ff <= XW'(s1_p0_ff[0]) + XW'(s1_p0_ff[1]) + XW'(s1_p0_ff[2]);
         s2_sum1_ff <= XW'(s1_p1_ff[0]) + XW'(s1_p1_ff[1]) + XW'(s1_p1_ff[2]);
         for (int i = 0; i < 3; i++)
            s2_cd_ff[i] <= (PW+1)'(s1_c_ff[2*i]) - (PW+1)'(s1_c_ff[2*i+1]);
      end
   end

   // stage 3: direct results, radicand and projection operands
   logic [2:0][W-1:0]         vec_in;
   logic [W-1:0]              sc_in;
   logic signed [XW-1:0]      ax, bx, abs0;
   logic                      s3_vld_ff;
   op_type                    s3_op_ff;
   logic [2:0][W-1:0]         s3_vec_ff, s3_bv_ff;
   logic [W-1:0]              s3_sc_ff, s3_s_ff;
   logic [PW-1:0]             s3_rad_ff, s3_abmag_ff, s3_bb_ff;
   logic                      s3_abneg_ff;

   always_comb begin
      ax = '0;
      bx = '0;
      for (int i = 0; i < 3; i++) begin
         ax = XW'($signed(s2_a_ff[i]));
         bx = XW'($signed(s2_b_ff[i]));
         case (s2_op_ff)
            OP_NEG:   vec_in[i] = sat(-ax);
            OP_SCALE: vec_in[i] = sat(XW'(s2_p0_ff[i] >>> F));
            OP_ADD:   vec_in[i] = sat(ax + bx);
            OP_SUB:   vec_in[i] = sat(ax - bx);
            OP_CROSS: vec_in[i] = sat(XW'(s2_cd_ff[i] >>> F));
            OP_DIV, OP_NORM, OP_PROJ, OP_REJ: vec_in[i] = s2_a_ff[i];
            default:  vec_in[i] = '0;
         endcase
      end
      sc_in = (s2_op_ff == OP_DOT) ? sat(s2_sum0_ff >>> F) : '0;
      abs0  = s2_sum0_ff[XW-1] ? -s2_sum0_ff : s2_sum0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (en) s3_vld_ff <= s2_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_op_ff    <= s2_op_ff;
         s3_vec_ff   <= vec_in;
         s3_bv_ff    <= s2_b_ff;
         s3_sc_ff    <= sc_in;
         s3_s_ff     <= s2_s_ff;
         s3_rad_ff   <= s2_sum0_ff[PW-1:0];
         s3_abmag_ff <= abs0[PW-1:0];
         s3_abneg_ff <= s2_sum0_ff[XW-1];
         s3_bb_ff    <= s2_sum1_ff[PW-1:0];
      end
   end

   assign out_valid = s3_vld_ff;
   assign out_op    = s3_op_ff;
   assign out_vec   = s3_vec_ff;
   assign out_bv    = s3_bv_ff;
   assign out_sc    = s3_sc_ff;
   assign out_s     = s3_s_ff;
   assign out_rad   = s3_rad_ff;
   assign out_abmag = s3_abmag_ff;
   assign out_abneg = s3_abneg_ff;
   assign out_bb    = s3_bb_ff;

endmodule
`default_nettype wire

### src/v3a_back.sv
// Back end of the vector unit: quotient saturation, projection multiply and
// final selection into the output register. Depends on v3a_pkg.
`default_nettype none
module v3a_back #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  v3a_pkg::op_type     op,
   input  logic                dz,
   input  logic [2:0]          ovf,
   input  logic [2:0]          qneg,
   input  logic [2:0][W-1:0]   q,
   input  logic [2:0][W-1:0]   vec,
   input  logic [2:0][W-1:0]   bv,
   input  logic [W-1:0]        sc,
   output logic                out_valid,
   output logic [2:0][W-1:0]   out_r,
   output logic [W-1:0]        out_sc,
   output logic                out_dz
);
   import v3a_pkg::*;

   localparam int PW = 2 * W;
   localparam int XW = 2 * W + 2;
   localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

   function automatic logic [W-1:0] sat(input logic [XW-1:0] v);
      logic [XW-W:0] hi;
      hi = v[XW-1:W-1];
      if (&hi || ~|hi) sat = v[W-1:0];
      else if (v[XW-1]) sat = SMIN;
      else sat = SMAX;
   endfunction

   function automatic logic [W-1:0] qsat(input logic [W-1:0] m, input logic o,
                                         input logic n);
      if (o) qsat = n ? SMIN : SMAX;
      else if (!n) qsat = m[W-1] ? SMAX : m;
      else if (m[W-1] && |m[W-2:0]) qsat = SMIN;
      else qsat = -m;
   endfunction

   // stage 6: signed, saturated quotients
   logic                 b6_vld_ff, b6_dz_ff;
   op_type               b6_op_ff;
   logic [2:0][W-1:0]    b6_t_ff, b6_vec_ff, b6_bv_ff;
   logic [W-1:0]         b6_sc_ff;

   always_ff @(posedge clock) begin
      if (reset) b6_vld_ff <= 1'b0;
      else if (en) b6_vld_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b6_op_ff  <= op;
         b6_dz_ff  <= dz;
         b6_vec_ff <= vec;
         b6_bv_ff  <= bv;
         b6_sc_ff  <= sc;
         for (int i = 0; i < 3; i++) b6_t_ff[i] <= qsat(q[i], ovf[i], qneg[i]);
      end
   end

   // stage 7: b * t for projection
   logic                 b7_vld_ff, b7_dz_ff;
   op_type               b7_op_ff;
   logic [2:0][W-1:0]    b7_t_ff, b7_vec_ff;
   logic [W-1:0]         b7_sc_ff;
   logic signed [PW-1:0] b7_p_ff [3];

   always_ff @(posedge clock) begin
      if (reset) b7_vld_ff <= 1'b0;
      else if (en) b7_vld_ff <= b6_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b7_op_ff  <= b6_op_ff;
         b7_dz_ff  <= b6_dz_ff;
         b7_t_ff   <= b6_t_ff;
         b7_vec_ff <= b6_vec_ff;
         b7_sc_ff  <= b6_sc_ff;
         for (int i = 0; i < 3; i++)
            b7_p_ff[i] <= PW'($signed(b6_bv_ff[i])) * PW'($signed(b6_t_ff[0]));
      end
   end

   // stage 8: selection into the output register
   logic [2:0][W-1:0]    r_in;
   logic [W-1:0]         sc_in;
   logic signed [XW-1:0] px, ax;
   logic                 o_vld_ff, o_dz_ff;
   logic [2:0][W-1:0]    o_r_ff;
   logic [W-1:0]         o_sc_ff;

   always_comb begin
      px = '0;
      ax = '0;
      for (int i = 0; i < 3; i++) begin
         px = XW'(b7_p_ff[i] >>> F);
         ax = XW'($signed(b7_vec_ff[i]));
         case (b7_op_ff)
            OP_DIV, OP_NORM: r_in[i] = b7_t_ff[i];
            OP_PROJ:         r_in[i] = sat(px);
            OP_REJ:          r_in[i] = sat(ax - px);
            default:         r_in[i] = b7_vec_ff[i];
         endcase
         if (b7_dz_ff) r_in[i] = '0;
      end
      sc_in = b7_dz_ff ? '0 : b7_sc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) o_vld_ff <= 1'b0;
      else if (en) o_vld_ff <= b7_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_r_ff  <= r_in;
         o_sc_ff <= sc_in;
         o_dz_ff <= b7_dz_ff;
      end
   end

   assign out_valid = o_vld_ff;
   assign out_r     = o_r_ff;
   assign out_sc    = o_sc_ff;
   assign out_dz    = o_dz_ff;

endmodule
`default_nettype wire

### src/vec3_arith_unit.sv
// Top level of the 3D vector arithmetic unit (signed fixed point).
// Depends on v3a_pkg, v3a_front, v3a_sqrt_cell, v3a_div_cell, v3a_back.
//
// One item is accepted per cycle while req_tready is high, and every item yields
// one result, in order. The pipeline holds three front stages, a square root
// chain of DATA_WIDTH cells, one divider setup stage, a divider chain of
// DATA_WIDTH cells and three back stages. Each chain cell settles one result
// bit. The whole pipeline advances whenever the output register is empty or
// being taken, so req_tready drops only while a result waits at rsp with
// rsp_tready low.
`default_nettype none
module vec3_arith_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
   input  logic [((7*DATA_WIDTH+7)/8)*8-1:0]      req_tdata,
   // operation
   input  v3a_pkg::op_type                        req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // r_x, r_y, r_z, scalar_out
   output logic [((4*DATA_WIDTH+7)/8)*8-1:0]      rsp_tdata,
   // div_by_zero
   output logic                                   rsp_tuser
);
   import v3a_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int PW  = 2 * W;
   localparam int NW  = 2 * W + F;
   localparam int OBW = ((4*DATA_WIDTH+7)/8)*8;
   localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

   typedef struct packed {
      op_type               op;
      logic [2:0][W-1:0]    vec;
      logic [2:0][W-1:0]    bv;
      logic [W-1:0]         sc;
      logic [W-1:0]         s;
      logic [PW-1:0]        abmag;
      logic                 abneg;
      logic [PW-1:0]        bb;
   } sq_ctx_type;

   typedef struct packed {
      op_type               op;
      logic                 dz;
      logic [2:0]           ovf;
      logic [2:0]           qneg;
      logic [2:0][W-1:0]    vec;
      logic [2:0][W-1:0]    bv;
      logic [W-1:0]         sc;
   } dv_ctx_type;

   logic pipe_en;
   logic out_valid;

   assign pipe_en    = !out_valid || rsp_tready;
   assign req_tready = pipe_en;

   // front end
   logic [2:0][W-1:0] in_a, in_b;
   logic [W-1:0]      in_s;
   sq_ctx_type        sq_head;
   logic              f_valid;
   logic [PW-1:0]     f_rad;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_a[i] = req_tdata[i*W +: W];
         in_b[i] = req_tdata[(3+i)*W +: W];
      end
      in_s = req_tdata[6*W +: W];
   end

   v3a_front #(.W(W), .F(F)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_tvalid),
      .op        (req_tuser),
      .a         (in_a),
      .b         (in_b),
      .s         (in_s),
      .out_valid (f_valid),
      .out_op    (sq_head.op),
      .out_vec   (sq_head.vec),
      .out_bv    (sq_head.bv),
      .out_sc    (sq_head.sc),
      .out_s     (sq_head.s),
      .out_rad   (f_rad),
      .out_abmag (sq_head.abmag),
      .out_abneg (sq_head.abneg),
      .out_bb    (sq_head.bb)
   );

   // square root chain
   logic [PW-1:0]  sq_rad  [0:W];
   logic [W+1:0]   sq_rem  [0:W];
   logic [W-1:0]   sq_root [0:W];
   sq_ctx_type     sq_ctx_ff [0:W-1];
   logic [W-1:0]   sq_vld_ff;

   assign sq_rad[0]  = f_rad;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar k = 0; k < W; k++) begin : g_sqrt
      v3a_sqrt_cell #(.W(W)) u_cell (
         .clock    (clock),
         .en       (pipe_en),
         .rad_in   (sq_rad[k]),
         .rem_in   (sq_rem[k]),
         .root_in  (sq_root[k]),
         .rad_out  (sq_rad[k+1]),
         .rem_out  (sq_rem[k+1]),
         .root_out (sq_root[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) sq_vld_ff <= '0;
      else if (pipe_en) sq_vld_ff <= {sq_vld_ff[W-2:0], f_valid};
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sq_ctx_ff[0] <= sq_head;
         for (int k = 1; k < W; k++) sq_ctx_ff[k] <= sq_ctx_ff[k-1];
      end
   end

   // divider setup
   sq_ctx_type          sc_t;
   logic [W-1:0]        root;
   logic [W-1:0]        amag [3];
   logic [W-1:0]        smag;
   logic [PW-1:0]       nmag [3];
   logic [NW-1:0]       nfull [3];
   logic [PW-1:0]       d_in;
   dv_ctx_type          ds_in;
   logic [2:0][PW-1:0]  rem0;
   logic [2:0][W-1:0]   num0;
   logic                ds_vld_ff;
   dv_ctx_type          ds_ctx_ff;
   logic [PW-1:0]       ds_d_ff;
   logic [2:0][PW-1:0]  ds_rem_ff;
   logic [2:0][W-1:0]   ds_num_ff;

   always_comb begin
      sc_t = sq_ctx_ff[W-1];
      root = sq_root[W];
      smag = sc_t.s[W-1] ? -sc_t.s : sc_t.s;
      ds_in.op   = sc_t.op;
      ds_in.vec  = sc_t.vec;
      ds_in.bv   = sc_t.bv;
      ds_in.sc   = sc_t.sc;
      ds_in.dz   = 1'b0;
      ds_in.qneg = '0;
      d_in       = '0;
      for (int i = 0; i < 3; i++) begin
         amag[i] = sc_t.vec[i][W-1] ? -sc_t.vec[i] : sc_t.vec[i];
         nmag[i] = '0;
      end
      case (sc_t.op)
         OP_DIV: begin
            d_in     = PW'(smag);
            ds_in.dz = (sc_t.s == '0);
            for (int i = 0; i < 3; i++) begin
               nmag[i]       = PW'(amag[i]);
               ds_in.qneg[i] = sc_t.vec[i][W-1] ^ sc_t.s[W-1];
            end
         end
         OP_NORM: begin
            d_in     = PW'(root);
            ds_in.dz = (root == '0);
            for (int i = 0; i < 3; i++) begin
               nmag[i]       = PW'(amag[i]);
               ds_in.qneg[i] = sc_t.vec[i][W-1];
            end
         end
         OP_PROJ, OP_REJ: begin
            d_in          = sc_t.bb;
            ds_in.dz      = (sc_t.bb == '0);
            nmag[0]       = sc_t.abmag;
            ds_in.qneg[0] = sc_t.abneg;
         end
         OP_LEN: begin
            ds_in.sc = root[W-1] ? SMAX : root;
         end
         default: begin
            d_in = '0;
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         nfull[i]     = {nmag[i], {F{1'b0}}};
         ds_in.ovf[i] = (NW'(nfull[i][NW-1:W]) >= NW'(d_in));
         rem0[i]      = PW'(nfull[i][NW-1:W]);
         num0[i]      = nfull[i][W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ds_vld_ff <= 1'b0;
      else if (pipe_en) ds_vld_ff <= sq_vld_ff[W-1];
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ds_ctx_ff <= ds_in;
         ds_d_ff   <= d_in;
         ds_rem_ff <= rem0;
         ds_num_ff <= num0;
      end
   end

   // divider chain
   logic [PW-1:0]       dv_d   [0:W];
   logic [2:0][PW-1:0]  dv_rem [0:W];
   logic [2:0][W-1:0]   dv_num [0:W];
   logic [2:0][W-1:0]   dv_q   [0:W];
   dv_ctx_type          dv_ctx_ff [0:W-1];
   logic [W-1:0]        dv_vld_ff;

   assign dv_d[0]   = ds_d_ff;
   assign dv_rem[0] = ds_rem_ff;
   assign dv_num[0] = ds_num_ff;
   assign dv_q[0]   = '0;

   for (genvar k = 0; k < W; k++) begin : g_div
      v3a_div_cell #(.W(W)) u_cell (
         .clock   (clock),
         .en      (pipe_en),
         .d_in    (dv_d[k]),
         .rem_in  (dv_rem[k]),
         .num_in  (dv_num[k]),
         .q_in    (dv_q[k]),
         .d_out   (dv_d[k+1]),
         .rem_out (dv_rem[k+1]),
         .num_out (dv_num[k+1]),
         .q_out   (dv_q[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) dv_vld_ff <= '0;
      else if (pipe_en) dv_vld_ff <= {dv_vld_ff[W-2:0], ds_vld_ff};
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dv_ctx_ff[0] <= ds_ctx_ff;
         for (int k = 1; k < W; k++) dv_ctx_ff[k] <= dv_ctx_ff[k-1];
      end
   end

   // back end
   dv_ctx_type        dv_tail;
   logic [2:0][W-1:0] out_r;
   logic [W-1:0]      out_sc;

   assign dv_tail = dv_ctx_ff[W-1];

   v3a_back #(.W(W), .F(F)) u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (dv_vld_ff[W-1]),
      .op        (dv_tail.op),
      .dz        (dv_tail.dz),
      .ovf       (dv_tail.ovf),
      .qneg      (dv_tail.qneg),
      .q         (dv_q[W]),
      .vec       (dv_tail.vec),
      .bv        (dv_tail.bv),
      .sc        (dv_tail.sc),
      .out_valid (out_valid),
      .out_r     (out_r),
      .out_sc    (out_sc),
      .out_dz    (rsp_tuser)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = OBW'({out_sc, out_r[2], out_r[1], out_r[0]});

   // checks
   a_dz_matches_divisor: assert property (@(posedge clock) disable iff (reset)
      ds_vld_ff && (ds_ctx_ff.op == OP_DIV || ds_ctx_ff.op == OP_NORM ||
                    ds_ctx_ff.op == OP_PROJ || ds_ctx_ff.op == OP_REJ)
      |-> (ds_ctx_ff.dz == (ds_d_ff == '0)))
      else $error("divide-by-zero flag disagrees with divisor");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[W-1] && !dv_tail.dz && !dv_tail.ovf[0] &&
      (dv_tail.op == OP_DIV || dv_tail.op == OP_NORM ||
       dv_tail.op == OP_PROJ || dv_tail.op == OP_REJ)
      |-> (dv_rem[W][0] < dv_d[W]))
      else $error("divider remainder not below divisor");

   a_sqrt_rem_bound: assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff[W-1] |-> ((W+2)'(sq_rem[W]) <= (W+2)'({sq_root[W], 1'b0})))
      else $error("square root remainder exceeds 2*root");

   a_chains_drained: assert property (@(posedge clock) disable iff (reset)
      (sq_vld_ff[W-1] |-> sq_rad[W] == '0) and (dv_vld_ff[W-1] |-> dv_num[W] == '0))
      else $error("cell chain did not consume all operand bits");

   a_dz_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("divide-by-zero item carries nonzero data");

endmodule
`default_nettype wire
